@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared defaults, operation and status codes, and the per-cycle cell command
// for the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

   // default geometry
   localparam int DEQ_DEPTH      = 8;
   localparam int DEQ_DATA_WIDTH = 32;

   // field widths fixed by the interface
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;

   // command broadcast to every cell, already qualified by accept and status
   typedef struct packed {
      logic ins_front;
      logic ins_back;
      logic rem_front;
      logic rem_back;
   } cell_cmd_type;

endpackage : deq_pkg

`default_nettype wire

@@ rtl/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row. Shifts toward the back on push front,
// toward the front on pop front, loads the word on push back when it is the
// first free slot, and forwards two OR chains that pick the back word and the
// word just past the back.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell
   import deq_pkg::*;
#(
   parameter int DATA_WIDTH = DEQ_DATA_WIDTH,
   parameter int CNT_W      = 4,
   parameter int INDEX      = 0
) (
   input  wire logic                  clock,
   input  wire cell_cmd_type          cmd,
   input  wire logic [DATA_WIDTH-1:0] in_word,
   input  wire logic [CNT_W-1:0]      count,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   input  wire logic [DATA_WIDTH-1:0] back_acc_in,
   input  wire logic [DATA_WIDTH-1:0] tail_acc_in,
   output logic      [DATA_WIDTH-1:0] back_acc_out,
   output logic      [DATA_WIDTH-1:0] tail_acc_out,
   output logic      [DATA_WIDTH-1:0] data_out
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  at_tail;
   logic                  at_back;

   // position of this cell relative to the occupancy
   assign at_tail = (count == CNT_W'(INDEX));
   assign at_back = (count == CNT_W'(INDEX + 1));

   // select the next word held here
   always_comb begin
      data_in = data_ff;
      if (cmd.ins_front) begin
         data_in = left_data;
      end else if (cmd.rem_front) begin
         data_in = right_data;
      end else if (cmd.ins_back && at_tail) begin
         data_in = in_word;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // merge this cell into the back and tail selection chains
   assign back_acc_out = back_acc_in | (at_back ? data_ff : '0);
   assign tail_acc_out = tail_acc_in | (at_tail ? data_ff : '0);
   assign data_out     = data_ff;

endmodule : deq_cell

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
// Double-ended queue of DEPTH words of DATA_WIDTH bits, kept in a row of cells
// with the front always in cell 0. Each request word carries one operation
// (push front, push back, pop front, pop back) and yields exactly one response
// word with the status, popped word, occupancy, front and back words and the
// empty and full flags after the operation. The cells update on the accept
// edge, and on the next edge the response register is loaded from the row's
// selection chains; a new request is taken only when no request is in flight
// and the response register is free or being read, so no request is taken
// until the last one is loaded there. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// double_ended_queue
// Top level: request decode, occupancy counter, cell row and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEQ_DEPTH,
   parameter int DATA_WIDTH = DEQ_DATA_WIDTH,
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [OP_W-1:0]       req_op,
   input  wire logic [DATA_WIDTH-1:0] req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [DATA_WIDTH-1:0] rsp_popped_value,
   output logic      [STATUS_W-1:0]   rsp_status,
   output logic      [CNT_W-1:0]      rsp_occupancy,
   output logic      [DATA_WIDTH-1:0] rsp_front_value,
   output logic      [DATA_WIDTH-1:0] rsp_back_value,
   output logic                       rsp_is_empty_flag,
   output logic                       rsp_is_full_flag
);

   logic                  accept;
   logic                  queue_full;
   logic                  queue_empty;
   cell_cmd_type          cmd;
   logic [STATUS_W-1:0]   status_in;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  calc_ff, calc_in;
   logic                  tail_pop_ff;
   logic [DATA_WIDTH-1:0] popped_ff;
   logic [STATUS_W-1:0]   status_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_popped_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic [DATA_WIDTH-1:0] rsp_front_ff;
   logic [DATA_WIDTH-1:0] rsp_back_ff;

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DATA_WIDTH-1:0] back_acc  [DEPTH+1];
   logic [DATA_WIDTH-1:0] tail_acc  [DEPTH+1];

   // take a request when no word is in flight and the response slot frees up
   assign req_ready = !reset && !calc_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign queue_full  = (count_ff == CNT_W'(DEPTH));
   assign queue_empty = (count_ff == '0);

   // decode the operation and refuse it on full or empty
   always_comb begin
      cmd       = '0;
      status_in = ST_DONE;
      unique case (req_op)
         OP_PUSH_FRONT: begin
            if (queue_full) status_in = ST_FULL;
            else            cmd.ins_front = accept;
         end
         OP_PUSH_BACK: begin
            if (queue_full) status_in = ST_FULL;
            else            cmd.ins_back = accept;
         end
         OP_POP_FRONT: begin
            if (queue_empty) status_in = ST_EMPTY;
            else             cmd.rem_front = accept;
         end
         OP_POP_BACK: begin
            if (queue_empty) status_in = ST_EMPTY;
            else             cmd.rem_back = accept;
         end
         default: status_in = ST_DONE;
      endcase
   end

   // advance the occupancy counter
   always_comb begin
      count_in = count_ff;
      if (cmd.ins_front || cmd.ins_back) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.rem_front || cmd.rem_back) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign calc_in = accept ? 1'b1 : 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         calc_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         calc_ff  <= calc_in;
      end
   end

   // hold what the response needs from the accept cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         tail_pop_ff <= cmd.rem_back;
         popped_ff   <= cmd.rem_front ? cell_data[0] : '0;
         status_ff   <= status_in;
      end
   end

   // row of cells, front in cell 0
   assign back_acc[0] = '0;
   assign tail_acc[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = req_value;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      deq_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_W      (CNT_W),
         .INDEX      (i)
      ) u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .in_word      (req_value),
         .count        (count_ff),
         .left_data    (left_data),
         .right_data   (right_data),
         .back_acc_in  (back_acc[i]),
         .tail_acc_in  (tail_acc[i]),
         .back_acc_out (back_acc[i+1]),
         .tail_acc_out (tail_acc[i+1]),
         .data_out     (cell_data[i])
      );
   end

   // load the response register in the cycle after accept
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (calc_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // after a back pop the removed word still sits just past the new back
   always_ff @(posedge clock) begin
      if (calc_ff) begin
         rsp_popped_ff <= tail_pop_ff ? tail_acc[DEPTH] : popped_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
         rsp_front_ff  <= queue_empty ? '0 : cell_data[0];
         rsp_back_ff   <= back_acc[DEPTH];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_value  = rsp_popped_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_occupancy     = rsp_count_ff;
   assign rsp_front_value   = rsp_front_ff;
   assign rsp_back_value    = rsp_back_ff;
   assign rsp_is_empty_flag = (rsp_count_ff == '0);
   assign rsp_is_full_flag  = (rsp_count_ff == CNT_W'(DEPTH));

endmodule : double_ended_queue

`default_nettype wire

@@ rtl/deq_checker.sv @@
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEQ_DEPTH,
   parameter int DATA_WIDTH = DEQ_DATA_WIDTH,
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [DATA_WIDTH-1:0] rsp_popped_value,
   input wire logic [STATUS_W-1:0]   rsp_status,
   input wire logic [CNT_W-1:0]      rsp_occupancy,
   input wire logic [DATA_WIDTH-1:0] rsp_front_value,
   input wire logic [DATA_WIDTH-1:0] rsp_back_value,
   input wire logic                  rsp_is_empty_flag
);

   // an empty queue shows no count and no words
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty_flag |->
         rsp_occupancy == '0 && rsp_front_value == '0 && rsp_back_value == '0)
      else $error("empty response shows stale words");

   // a refused operation removes nothing
   a_refused_no_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY) |->
         rsp_popped_value == '0)
      else $error("refused operation reports a popped word");

   // occupancy never exceeds the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= CNT_W'(DEPTH))
      else $error("occupancy beyond depth");

   // every new response follows an accepted request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a request");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_popped_value))
      else $error("stalled response changed");

endmodule : deq_checker

bind double_ended_queue deq_checker #(
   .DEPTH      (DEPTH),
   .DATA_WIDTH (DATA_WIDTH),
   .CNT_W      (CNT_W)
) u_deq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_popped_value  (rsp_popped_value),
   .rsp_status        (rsp_status),
   .rsp_occupancy     (rsp_occupancy),
   .rsp_front_value   (rsp_front_value),
   .rsp_back_value    (rsp_back_value),
   .rsp_is_empty_flag (rsp_is_empty_flag)
);

`default_nettype wire

@@ tb/sv/tb_double_ended_queue.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the double-ended queue: a directed table covers
// the empty and full refusals, value extremes and pointer wrap, then about
// 2000 biased random operations run under four idle patterns. Every response
// word is checked field by field against typed-in results or the ring model.
// ----------------------------------------------------------------------------
module tb_double_ended_queue
   import deq_pkg::*;
();

   localparam int DEPTH       = DEQ_DEPTH;
   localparam int DW          = DEQ_DATA_WIDTH;
   localparam int CW          = $clog2(DEPTH + 1);
   localparam int N_DIRECTED  = 25;
   localparam int PHASE_ITEMS = 500;
   localparam int HOLD_AT     = 125;
   localparam int HOLD_CYCLES = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRED_DEPTH  = 64;

   typedef struct packed {
      logic [DW-1:0]       popped_value;
      logic [STATUS_W-1:0] status;
      logic [CW-1:0]       occupancy;
      logic [DW-1:0]       front_value;
      logic [DW-1:0]       back_value;
      logic                empty_flag;
      logic                full_flag;
   } deq_result_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [DW-1:0]   value;
      logic            checked;
      deq_result_type  want;
   } stim_row_type;

   localparam deq_result_type EMPTY_REFUSED =
      '{'0, ST_EMPTY, '0, '0, '0, 1'b1, 1'b0};
   localparam deq_result_type FULL_REFUSED =
      '{'0, ST_FULL, CW'(DEPTH), 32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b0, 1'b1};

   // directed rows; only the obvious results are typed in, the rest predicted
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{OP_POP_FRONT,  32'h1234_5678, 1'b1, EMPTY_REFUSED},
      '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, EMPTY_REFUSED},
      '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1,
        '{'0, ST_DONE, CW'(1), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0}},
      '{OP_PUSH_BACK,  32'h0000_0000, 1'b1,
        '{'0, ST_DONE, CW'(2), 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0}},
      '{OP_POP_FRONT,  32'hA5A5_A5A5, 1'b1,
        '{32'hFFFF_FFFF, ST_DONE, CW'(1), 32'h0, 32'h0, 1'b0, 1'b0}},
      '{OP_POP_BACK,   32'h5A5A_5A5A, 1'b1,
        '{32'h0, ST_DONE, CW'(0), 32'h0, 32'h0, 1'b1, 1'b0}},
      '{OP_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h8000_0000, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h5555_5555, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, '0},
      '{OP_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h1357_9BDF, 1'b1, FULL_REFUSED},
      '{OP_PUSH_BACK,  32'h2468_ACE0, 1'b1, FULL_REFUSED},
      '{OP_POP_FRONT,  32'h0,         1'b0, '0},
      '{OP_POP_BACK,   32'h0,         1'b0, '0},
      '{OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0, '0},
      '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b0, '0},
      '{OP_POP_BACK,   32'h0,         1'b0, '0},
      '{OP_POP_BACK,   32'h0,         1'b0, '0},
      '{OP_POP_FRONT,  32'h0,         1'b0, '0},
      '{OP_POP_FRONT,  32'h0,         1'b0, '0},
      '{OP_POP_FRONT,  32'h0,         1'b1, EMPTY_REFUSED}
   };

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [OP_W-1:0] req_op    = OP_PUSH_FRONT;
   logic [DW-1:0]   req_value = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [DW-1:0]       rsp_popped_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [CW-1:0]       rsp_occupancy;
   logic [DW-1:0]       rsp_front_value;
   logic [DW-1:0]       rsp_back_value;
   logic                rsp_is_empty_flag;
   logic                rsp_is_full_flag;

   double_ended_queue #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DW)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_front_value   (rsp_front_value),
      .rsp_back_value    (rsp_back_value),
      .rsp_is_empty_flag (rsp_is_empty_flag),
      .rsp_is_full_flag  (rsp_is_full_flag)
   );

   always #2 clock = ~clock;

   // ring model of the queue and its bookkeeping
   logic [DW-1:0]  ring_words [DEPTH];
   int             ring_head     = 0;
   int             ring_tail     = 0;
   int             ring_fill     = 0;
   int             full_refusals = 0;
   int             empty_refusals = 0;
   deq_result_type pred_store [PRED_DEPTH];
   int             pred_wr        = 0;
   int             pred_rd        = 0;
   int             mismatch_count = 0;
   int             results_seen   = 0;
   int             words_sent     = 0;
   int             req_idle_pct   = 0;
   int             rsp_stall_pct  = 0;
   int             hold_left      = 0;
   bit             hold_done      = 1'b0;
   int             cycle_count    = 0;

   // apply one operation to the ring model and return the response word
   function automatic deq_result_type apply_deque_op(input logic [OP_W-1:0] op,
                                                     input logic [DW-1:0] value);
      deq_result_type r;
      r        = '0;
      r.status = ST_DONE;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
         if (ring_fill == DEPTH) begin
            r.status = ST_FULL;
            full_refusals++;
         end else if (op == OP_PUSH_FRONT) begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring_words[ring_head] = value;
            ring_fill++;
         end else begin
            ring_words[ring_tail] = value;
            ring_tail = (ring_tail + 1) % DEPTH;
            ring_fill++;
         end
      end else begin
         if (ring_fill == 0) begin
            r.status = ST_EMPTY;
            empty_refusals++;
         end else if (op == OP_POP_FRONT) begin
            r.popped_value = ring_words[ring_head];
            ring_head = (ring_head + 1) % DEPTH;
            ring_fill--;
         end else begin
            ring_tail = (ring_tail + DEPTH - 1) % DEPTH;
            r.popped_value = ring_words[ring_tail];
            ring_fill--;
         end
      end
      if (ring_fill != 0) begin
         r.front_value = ring_words[ring_head];
         r.back_value  = ring_words[(ring_tail + DEPTH - 1) % DEPTH];
      end
      r.occupancy  = CW'(ring_fill);
      r.empty_flag = (ring_fill == 0);
      r.full_flag  = (ring_fill == DEPTH);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                  input logic [DW-1:0] want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("[%0t] response %0d: %s is %h, expected %h",
                  $realtime, results_seen, what, got, want);
   endtask

   // offer one word, hold it until accepted, then queue its prediction
   task automatic send_word(input logic [OP_W-1:0] op, input logic [DW-1:0] value,
                            input logic checked, input deq_result_type want);
      deq_result_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_deque_op(op, value);
      pred_store[pred_wr % PRED_DEPTH] = checked ? want : predicted;
      pred_wr++;
      words_sent++;
   endtask

   // drop valid and wait until every queued response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pred_wr != pred_rd) @(posedge clock);
   endtask

   // pick an operation; bias 1 leans to pushes, bias 2 to pops
   function automatic logic [OP_W-1:0] pick_op(input int bias);
      logic [OP_W-1:0] push_op;
      logic [OP_W-1:0] pop_op;
      push_op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      pop_op  = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      case (bias)
         1: return ($urandom_range(99) < 80) ? push_op : pop_op;
         2: return ($urandom_range(99) < 80) ? pop_op : push_op;
         default: return $urandom_range(1) ? push_op : pop_op;
      endcase
   endfunction

   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return DW'($urandom);
      endcase
   endfunction

   // receiver: random stalls, plus one long hold-off once traffic is running
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // check each accepted response word against the oldest prediction
   always @(posedge clock) begin
      deq_result_type got;
      deq_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_popped_value, rsp_status, rsp_occupancy, rsp_front_value,
                 rsp_back_value, rsp_is_empty_flag, rsp_is_full_flag};
         if (pred_wr == pred_rd) begin
            report_mismatch("unexpected word, popped_value", got.popped_value, '0);
         end else begin
            want = pred_store[pred_rd % PRED_DEPTH];
            pred_rd++;
            if (got.popped_value !== want.popped_value)
               report_mismatch("popped_value", got.popped_value, want.popped_value);
            if (got.status !== want.status)
               report_mismatch("status", DW'(got.status), DW'(want.status));
            if (got.occupancy !== want.occupancy)
               report_mismatch("occupancy", DW'(got.occupancy), DW'(want.occupancy));
            if (got.front_value !== want.front_value)
               report_mismatch("front_value", got.front_value, want.front_value);
            if (got.back_value !== want.back_value)
               report_mismatch("back_value", got.back_value, want.back_value);
            if (got.empty_flag !== want.empty_flag)
               report_mismatch("is_empty_flag", DW'(got.empty_flag),
                               DW'(want.empty_flag));
            if (got.full_flag !== want.full_flag)
               report_mismatch("is_full_flag", DW'(got.full_flag), DW'(want.full_flag));
         end
         results_seen <= results_seen + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int bias;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[i])
         send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value,
                   DIRECTED_ROWS[i].checked, DIRECTED_ROWS[i].want);
      drain_responses();

      // random phases: no idling, sender idle, receiver stall, both
      bias = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 48; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 48; end
            default: begin req_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 24 == 0) bias = $urandom_range(2);
            send_word(pick_op(bias), pick_value(), 1'b0, '0);
         end
         drain_responses();
      end

      // let any stray response word show up
      repeat (8) @(posedge clock);
      if (pred_wr != pred_rd)
         report_mismatch("responses missing", DW'(pred_wr - pred_rd), '0);

      $display("Sent %0d request words (%0d from the table, %0d random)",
               words_sent, N_DIRECTED, words_sent - N_DIRECTED);
      $display("over four idle patterns; %0d pushes refused on full, %0d pops on empty",
               full_refusals, empty_refusals);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
